>>> design/xcs_pkg.sv
// shared types, constants and helper functions for the chained stream cipher
// depends on nothing; used by every design file through scoped names
package xcs_pkg;

	// key and table sizes
	localparam int MAX_KEY_BYTES = 16;
	localparam int MIN_KEY_BYTES = 3;
	localparam int SALT_LEN      = 8;
	localparam int ROUNDS        = 19;
	localparam int WORK_MAX      = 2 * MAX_KEY_BYTES + SALT_LEN;
	localparam int STREAM_MAX    = 2 * WORK_MAX;

	localparam int RAW_AW    = $clog2(MAX_KEY_BYTES);
	localparam int RAW_CW    = $clog2(MAX_KEY_BYTES + 1);
	localparam int WORK_AW   = $clog2(WORK_MAX);
	localparam int STREAM_AW = $clog2(STREAM_MAX);
	localparam int LEN_W     = $clog2(STREAM_MAX + 1);
	localparam int RND_W     = $clog2(ROUNDS);

	// reciprocals for the small signed remainders, exact for magnitudes up to 256
	localparam int RCP_SH = 16;
	localparam logic [13:0] RCP26 = 14'(65536 / 26 + 1);
	localparam logic [13:0] RCP12 = 14'(65536 / 12 + 1);
	localparam logic [13:0] RCP15 = 14'(65536 / 15 + 1);
	localparam logic [13:0] RCP7  = 14'(65536 / 7 + 1);
	localparam logic [13:0] RCP13 = 14'(65536 / 13 + 1);

	// action codes on the input port
	localparam logic [1:0] ACT_KEY  = 2'd0;
	localparam logic [1:0] ACT_ENC  = 2'd1;
	localparam logic [1:0] ACT_DEC  = 2'd2;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef enum logic [1:0] {
		CMD_KEY,
		CMD_ENC,
		CMD_DEC
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] data_byte;
		logic       last;
		logic       start;
	} q_item_t;

	// head of the queue as seen by the back end
	typedef struct packed {
		logic    valid;
		q_item_t item;
	} q_head_t;

	typedef enum logic [2:0] {
		ST_DATA      = 3'd0,
		ST_KEY_READY = 3'd1,
		ST_KEY_SHORT = 3'd2,
		ST_KEY_LONG  = 3'd3,
		ST_NO_KEY    = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_DATA1,
		B_DATA2,
		B_FILL0,
		B_FILL1,
		B_FILL2,
		B_SRC,
		B_TERM,
		B_W0,
		B_W1,
		B_W2
	} bstate_t;

	// salt bytes appended to the second expansion pass
	function automatic logic [7:0] salt_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h73;
			3'd1: b = 8'h6F;
			3'd2: b = 8'h6D;
			3'd3: b = 8'h65;
			3'd4: b = 8'h53;
			3'd5: b = 8'h61;
			3'd6: b = 8'h6C;
			default: b = 8'h74;
		endcase
		return b;
	endfunction

	// truncating remainder of a signed 10-bit value by a small constant, low 8 bits
	function automatic logic [7:0] smod(input logic [9:0] v, input logic [4:0] c,
		input logic [13:0] m);
		logic        neg;
		logic [9:0]  mag;
		logic [22:0] prod;
		logic [6:0]  q;
		logic [8:0]  qc;
		logic [8:0]  r;
		neg  = v[9];
		mag  = neg ? (~v + 10'd1) : v;
		prod = 23'(mag[8:0]) * 23'(m);
		q    = prod[22:RCP_SH];
		qc   = 9'(q) * 9'(c);
		r    = mag[8:0] - qc;
		return neg ? (8'd0 - r[7:0]) : r[7:0];
	endfunction

endpackage

>>> design/xcs_front.sv
// front end: accepts input words, sorts them into commands, queues them
// depends on xcs_pkg
module xcs_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       action,
	input  logic [7:0]       data_byte,
	input  logic             key_last,
	input  logic             msg_start,
	output xcs_pkg::q_head_t head,
	input  logic             pop
);

	xcs_pkg::q_item_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             push;
	xcs_pkg::q_item_t item_d;

	// command decode; the unused action code is never pushed into the queue
	always_comb begin
		item_d.data_byte = data_byte;
		item_d.last      = key_last;
		item_d.start     = msg_start;
		case (action)
			xcs_pkg::ACT_KEY: item_d.cmd = xcs_pkg::CMD_KEY;
			xcs_pkg::ACT_ENC: item_d.cmd = xcs_pkg::CMD_ENC;
			default:          item_d.cmd = xcs_pkg::CMD_DEC;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready && (action != xcs_pkg::ACT_NONE);

	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = mem_q[rd_ptr_q];

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= item_d;
	end

endmodule

>>> design/xcs_back.sv
// back end: key store, two-pass key expansion sequencer, keystream XOR, result register
// depends on xcs_pkg
module xcs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  xcs_pkg::q_head_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       result_byte,
	output logic [2:0]       status
);

	localparam int LW = xcs_pkg::LEN_W;

	xcs_pkg::bstate_t state_q, state_d;

	// memories
	logic [7:0] raw_mem    [xcs_pkg::MAX_KEY_BYTES];
	logic [7:0] work_mem   [xcs_pkg::WORK_MAX];
	logic [7:0] stream_mem [xcs_pkg::STREAM_MAX];

	logic                         raw_we;
	logic [xcs_pkg::RAW_AW-1:0]    raw_wa, raw_ra0, raw_ra1;
	logic [7:0]                   raw_wd, raw_rd0, raw_rd1;
	logic                         work_we;
	logic [xcs_pkg::WORK_AW-1:0]   work_wa, work_ra0, work_ra1;
	logic [7:0]                   work_rd0, work_rd1;
	logic                         stream_we;
	logic [xcs_pkg::STREAM_AW-1:0] stream_wa, stream_ra0, stream_ra1;
	logic [7:0]                   stream_rd0, stream_rd1;

	// control state
	logic [xcs_pkg::RAW_CW-1:0] key_cnt_q;
	logic                      ovf_q;
	logic                      key_ready_q;
	logic [LW-1:0]             len_q, pos_q;
	logic [7:0]                chain_q;
	logic                      out_valid_q;

	// expansion counters
	logic                     pass_q;
	logic [LW-1:0]            sn_q, dm_q, salt_base_q;
	logic [LW-1:0]            i_q, la_q, ra_q, j3_q, j6_q;
	logic [xcs_pkg::RND_W-1:0] rnd_q;

	// payload registers
	logic [7:0]       res_q;
	xcs_pkg::status_t stat_q;
	logic [7:0]       byte_q, chain_eff_q, x_q, fill_q;
	logic             enc_q;
	logic [LW-1:0]    pp3_q, pn_q;
	logic             sa_salt_q, sb_salt_q;
	logic [7:0]       sa_sbyte_q, sb_sbyte_q;
	logic [7:0]       r26_q, r12_q, r15_q, r7_q, r13_q, xv_q;

	// combinational helpers
	xcs_pkg::q_item_t          item;
	logic                      out_free;
	logic                      kw;
	logic [xcs_pkg::RAW_CW-1:0] new_cnt;
	logic                      ovf_eff;
	logic                      key_good;
	logic [LW-1:0]             p, pm2, pp3, pn;
	logic [LW-1:0]             src_a_idx, dst_ra, dst_wa;
	logic                      dst_we;
	logic [7:0]                dst_wd, dst_rd;
	logic [7:0]                src_a, src_b;
	logic [9:0]                lv, rv, sv;
	logic                      i_last, rnd_last;
	logic [LW-1:0]             i_nx, la_nx, ra_nx, j3_nx, j6_nx;
	logic                      out_set;
	logic [7:0]                out_res;
	xcs_pkg::status_t          out_stat;
	logic [7:0]                data_r;

	assign item     = head.item;
	assign out_free = !out_valid_q || out_ready;

	// key word decode
	assign kw       = key_cnt_q < xcs_pkg::RAW_CW'(xcs_pkg::MAX_KEY_BYTES);
	assign new_cnt  = kw ? key_cnt_q + 1'b1 : key_cnt_q;
	assign ovf_eff  = ovf_q || !kw;
	assign key_good = !ovf_eff && (new_cnt >= xcs_pkg::RAW_CW'(xcs_pkg::MIN_KEY_BYTES));

	// data word table positions
	always_comb begin
		p   = item.start ? '0 : pos_q;
		pm2 = (p >= LW'(2)) ? p - LW'(2) : p + len_q - LW'(2);
		pp3 = (p + LW'(3) >= len_q) ? p + LW'(3) - len_q : p + LW'(3);
		pn  = (p + LW'(1) == len_q) ? '0 : p + LW'(1);
	end

	// expansion step counters
	always_comb begin
		i_last   = (i_q + LW'(1) == dm_q);
		rnd_last = (rnd_q == xcs_pkg::RND_W'(xcs_pkg::ROUNDS - 1));
		i_nx     = i_last ? '0 : i_q + LW'(1);
		la_nx    = (la_q + LW'(1) == sn_q) ? '0 : la_q + LW'(1);
		ra_nx    = (ra_q + LW'(1) == sn_q) ? '0 : ra_q + LW'(1);
		j3_nx    = (j3_q + LW'(1) == dm_q) ? '0 : j3_q + LW'(1);
		j6_nx    = (j6_q + LW'(1) == dm_q) ? '0 : j6_q + LW'(1);
	end

	// source bytes, salt tail on the second pass
	always_comb begin
		if (!pass_q) begin
			src_a = raw_rd0;
			src_b = raw_rd1;
		end else begin
			src_a = sa_salt_q ? sa_sbyte_q : work_rd0;
			src_b = sb_salt_q ? sb_sbyte_q : work_rd1;
		end
		lv = {{2{src_a[7]}}, src_a};
		rv = {{2{src_b[7]}}, src_b};
		sv = lv + rv;
	end

	assign dst_rd = pass_q ? stream_rd0 : work_rd0;
	assign data_r = x_q ^ stream_rd0 ^ chain_eff_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			xcs_pkg::B_IDLE: begin
				if (head.valid && out_free) begin
					case (item.cmd)
						xcs_pkg::CMD_KEY: begin
							if (item.last && key_good)
								state_d = xcs_pkg::B_FILL0;
						end
						default: begin
							if (key_ready_q)
								state_d = xcs_pkg::B_DATA1;
						end
					endcase
				end
			end
			xcs_pkg::B_DATA1: state_d = xcs_pkg::B_DATA2;
			xcs_pkg::B_DATA2: state_d = xcs_pkg::B_IDLE;
			xcs_pkg::B_FILL0: state_d = xcs_pkg::B_FILL1;
			xcs_pkg::B_FILL1: state_d = xcs_pkg::B_FILL2;
			xcs_pkg::B_FILL2: begin
				if (i_last)
					state_d = xcs_pkg::B_SRC;
			end
			xcs_pkg::B_SRC:  state_d = xcs_pkg::B_TERM;
			xcs_pkg::B_TERM: state_d = xcs_pkg::B_W0;
			xcs_pkg::B_W0:   state_d = xcs_pkg::B_W1;
			xcs_pkg::B_W1:   state_d = xcs_pkg::B_W2;
			xcs_pkg::B_W2: begin
				if (i_last && rnd_last)
					state_d = pass_q ? xcs_pkg::B_IDLE : xcs_pkg::B_FILL0;
				else
					state_d = xcs_pkg::B_SRC;
			end
			default: state_d = xcs_pkg::B_IDLE;
		endcase
	end

	// state outputs: queue pop, memory ports, result load
	always_comb begin
		pop       = (state_q == xcs_pkg::B_IDLE) && head.valid && out_free;
		src_a_idx = (state_q == xcs_pkg::B_FILL0) ? '0 : la_q;
		out_set   = 1'b0;
		out_res   = 8'd0;
		out_stat  = xcs_pkg::ST_DATA;
		dst_ra    = i_q;
		dst_wa    = i_q;
		dst_we    = 1'b0;
		dst_wd    = fill_q;
		case (state_q)
			xcs_pkg::B_IDLE: begin
				if (pop) begin
					case (item.cmd)
						xcs_pkg::CMD_KEY: begin
							if (item.last && !key_good) begin
								out_set  = 1'b1;
								out_stat = ovf_eff ? xcs_pkg::ST_KEY_LONG
									: xcs_pkg::ST_KEY_SHORT;
							end
						end
						default: begin
							if (!key_ready_q) begin
								out_set  = 1'b1;
								out_stat = xcs_pkg::ST_NO_KEY;
							end
						end
					endcase
				end
			end
			xcs_pkg::B_DATA2: begin
				out_set = 1'b1;
				out_res = data_r;
			end
			xcs_pkg::B_FILL2: dst_we = 1'b1;
			xcs_pkg::B_TERM:  dst_ra = i_q;
			xcs_pkg::B_W0: begin
				dst_ra = j3_q;
				dst_we = 1'b1;
				dst_wd = dst_rd + r26_q + xv_q + r12_q;
			end
			xcs_pkg::B_W1: begin
				dst_ra = j6_q;
				dst_wa = j3_q;
				dst_we = 1'b1;
				dst_wd = dst_rd + xv_q + r15_q;
			end
			xcs_pkg::B_W2: begin
				dst_wa = j6_q;
				dst_we = 1'b1;
				dst_wd = dst_rd + r7_q + r13_q;
				if (i_last && rnd_last && pass_q) begin
					out_set  = 1'b1;
					out_stat = xcs_pkg::ST_KEY_READY;
				end
			end
			default: ;
		endcase
	end

	// memory port wiring
	always_comb begin
		raw_we  = pop && (item.cmd == xcs_pkg::CMD_KEY) && kw;
		raw_wa  = key_cnt_q[xcs_pkg::RAW_AW-1:0];
		raw_wd  = item.data_byte;
		raw_ra0 = src_a_idx[xcs_pkg::RAW_AW-1:0];
		raw_ra1 = ra_q[xcs_pkg::RAW_AW-1:0];

		work_we  = dst_we && !pass_q;
		work_wa  = dst_wa[xcs_pkg::WORK_AW-1:0];
		work_ra0 = pass_q ? src_a_idx[xcs_pkg::WORK_AW-1:0] : dst_ra[xcs_pkg::WORK_AW-1:0];
		work_ra1 = ra_q[xcs_pkg::WORK_AW-1:0];

		stream_we = dst_we && pass_q;
		stream_wa = dst_wa[xcs_pkg::STREAM_AW-1:0];
		case (state_q)
			xcs_pkg::B_IDLE:  stream_ra0 = p[xcs_pkg::STREAM_AW-1:0];
			xcs_pkg::B_DATA1: stream_ra0 = pp3_q[xcs_pkg::STREAM_AW-1:0];
			default:          stream_ra0 = dst_ra[xcs_pkg::STREAM_AW-1:0];
		endcase
		stream_ra1 = pm2[xcs_pkg::STREAM_AW-1:0];
	end

	// memories with registered reads
	always_ff @(posedge clk) begin
		if (raw_we)
			raw_mem[raw_wa] <= raw_wd;
		raw_rd0 <= raw_mem[raw_ra0];
		raw_rd1 <= raw_mem[raw_ra1];
	end

	always_ff @(posedge clk) begin
		if (work_we)
			work_mem[work_wa] <= dst_wd;
		work_rd0 <= work_mem[work_ra0];
		work_rd1 <= work_mem[work_ra1];
	end

	always_ff @(posedge clk) begin
		if (stream_we)
			stream_mem[stream_wa] <= dst_wd;
		stream_rd0 <= stream_mem[stream_ra0];
		stream_rd1 <= stream_mem[stream_ra1];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= xcs_pkg::B_IDLE;
			key_cnt_q   <= '0;
			ovf_q       <= 1'b0;
			key_ready_q <= 1'b0;
			len_q       <= '0;
			pos_q       <= '0;
			chain_q     <= 8'd0;
			out_valid_q <= 1'b0;
			pass_q      <= 1'b0;
			sn_q        <= '0;
			dm_q        <= '0;
			salt_base_q <= '0;
			i_q         <= '0;
			la_q        <= '0;
			ra_q        <= '0;
			j3_q        <= '0;
			j6_q        <= '0;
			rnd_q       <= '0;
		end else begin
			state_q <= state_d;
			if (out_set)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			// key word bookkeeping
			if (pop && item.cmd == xcs_pkg::CMD_KEY) begin
				if (item.last) begin
					key_cnt_q <= '0;
					ovf_q     <= 1'b0;
					if (!key_good) begin
						key_ready_q <= 1'b0;
					end else begin
						pass_q      <= 1'b0;
						sn_q        <= LW'(new_cnt);
						dm_q        <= LW'({new_cnt, 1'b0});
						salt_base_q <= LW'(new_cnt);
						i_q         <= '0;
					end
				end else begin
					key_cnt_q <= new_cnt;
					ovf_q     <= ovf_eff;
				end
			end

			// keystream position and chaining after a data word
			if (state_q == xcs_pkg::B_DATA2) begin
				pos_q   <= pn_q;
				chain_q <= enc_q ? data_r : byte_q;
			end

			// table fill sweep, then counter setup for the rounds
			if (state_q == xcs_pkg::B_FILL2) begin
				i_q <= i_nx;
				if (i_last) begin
					la_q  <= sn_q - LW'(2);
					ra_q  <= (sn_q == LW'(3)) ? '0 : LW'(3);
					j3_q  <= LW'(3);
					j6_q  <= (dm_q == LW'(6)) ? '0 : LW'(6);
					rnd_q <= '0;
				end
			end

			// one update step done
			if (state_q == xcs_pkg::B_W2) begin
				i_q  <= i_nx;
				la_q <= la_nx;
				ra_q <= ra_nx;
				j3_q <= j3_nx;
				j6_q <= j6_nx;
				if (i_last) begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_last) begin
						if (!pass_q) begin
							pass_q      <= 1'b1;
							sn_q        <= dm_q + LW'(xcs_pkg::SALT_LEN);
							dm_q        <= LW'({dm_q + LW'(xcs_pkg::SALT_LEN), 1'b0});
							salt_base_q <= dm_q;
							i_q         <= '0;
						end else begin
							len_q       <= dm_q;
							key_ready_q <= 1'b1;
							pos_q       <= '0;
							chain_q     <= 8'd0;
						end
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (out_set) begin
			res_q  <= out_res;
			stat_q <= out_stat;
		end
		if (pop) begin
			byte_q      <= item.data_byte;
			enc_q       <= (item.cmd == xcs_pkg::CMD_ENC);
			chain_eff_q <= item.start ? 8'd0 : chain_q;
			pp3_q       <= pp3;
			pn_q        <= pn;
		end
		if (state_q == xcs_pkg::B_DATA1)
			x_q <= byte_q ^ stream_rd0 ^ stream_rd1;
		if (state_q == xcs_pkg::B_FILL1)
			fill_q <= src_a;
		sa_salt_q  <= (src_a_idx >= salt_base_q);
		sb_salt_q  <= (ra_q >= salt_base_q);
		sa_sbyte_q <= xcs_pkg::salt_byte(3'(src_a_idx - salt_base_q));
		sb_sbyte_q <= xcs_pkg::salt_byte(3'(ra_q - salt_base_q));
		if (state_q == xcs_pkg::B_TERM) begin
			r26_q <= xcs_pkg::smod(lv, 5'd26, xcs_pkg::RCP26);
			r12_q <= xcs_pkg::smod(rv, 5'd12, xcs_pkg::RCP12);
			r15_q <= xcs_pkg::smod(sv, 5'd15, xcs_pkg::RCP15);
			r13_q <= xcs_pkg::smod(sv, 5'd13, xcs_pkg::RCP13);
			r7_q  <= xcs_pkg::smod({{2{src_a[7] ^ src_b[7]}}, src_a ^ src_b}, 5'd7,
				xcs_pkg::RCP7);
			xv_q  <= src_a ^ src_b;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_byte = res_q;
	assign status      = stat_q;

endmodule

>>> design/xor_chained_stream_cipher_top.sv
// top level of the chained three-tap XOR stream cipher
// depends on xcs_pkg, xcs_front and xcs_back
//
// Key words (action 0) are taken one per cycle while the back end is idle and its
// output register free, and give no result until the word marked key_last; a
// rejected key answers at once with status 2 or 3. A good key of n bytes runs two
// expansion passes on a single-write memory sequencer: each pass of m destination
// bytes (m = 2n, then 4n+16) runs a fill sweep, then 19 rounds of m update steps
// that read-modify-write, after which status 1 is given. A data word (encrypt or
// decrypt) passes the back end in steps: the pop starts two table reads, B_DATA1
// the third, and B_DATA2 forms the result, as the table memory has two read ports.
// A two-word queue lets the input side keep accepting while the back end or the
// output register is busy; the output register holds one result at a time.
module xor_chained_stream_cipher_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [7:0] data_byte,
	input  logic       key_last,
	input  logic       msg_start,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] result_byte,
	output logic [2:0] status
);

	xcs_pkg::q_head_t head;
	logic             pop;

	// accept and queue words
	xcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.data_byte (data_byte),
		.key_last  (key_last),
		.msg_start (msg_start),
		.head      (head),
		.pop       (pop)
	);

	// key expansion and data path
	xcs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_byte (result_byte),
		.status      (status)
	);

endmodule

>>> test/xcs_checker.sv
// scoreboard for the chained stream cipher: watches both channels, predicts, compares
// depends on xcs_pkg for the action and status codes and the table sizes
`timescale 1ns / 100ps
module xcs_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] action,
	input  logic [7:0] data_byte,
	input  logic       key_last,
	input  logic       msg_start,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] result_byte,
	input  logic [2:0] status,
	output int         fails,
	output int         pending,
	output int         words_out,
	output int         keys_made
);

	typedef struct {
		logic [7:0]       rbyte;
		xcs_pkg::status_t st;
	} cipher_word_t;

	typedef logic [7:0] byte_arr_t [xcs_pkg::STREAM_MAX];

	localparam logic [7:0] SALT [xcs_pkg::SALT_LEN] = '{8'h73, 8'h6F, 8'h6D, 8'h65,
		8'h53, 8'h61, 8'h6C, 8'h74};

	cipher_word_t expected_words [$];

	// predicted block state
	logic [7:0] key_bytes [xcs_pkg::MAX_KEY_BYTES];
	int         key_count;
	logic       key_spill;
	byte_arr_t  stream_tab;
	int         tab_len;
	logic       have_key;
	int         tab_pos;
	logic [7:0] chain;

	// one key schedule pass: n source bytes into 2n destination bytes, 19 rounds
	function automatic byte_arr_t schedule_pass(input byte_arr_t src, input int n);
		byte_arr_t dst;
		int m, lv, rv, xv, sv, j3, j6;
		logic [7:0] lb, rb;
		m = 2 * n;
		for (int i = 0; i < xcs_pkg::STREAM_MAX; i++)
			dst[i] = (i < m) ? src[0] : 8'd0;
		for (int r = 0; r < xcs_pkg::ROUNDS; r++) begin
			for (int i = 0; i < m; i++) begin
				lb = src[(i + n - 2) % n];
				rb = src[(i + 3) % n];
				lv = int'($signed(lb));
				rv = int'($signed(rb));
				xv = int'($signed(lb ^ rb));
				sv = lv + rv;
				j3 = (i + 3) % m;
				j6 = (i + 6) % m;
				dst[i] = 8'(int'(dst[i]) + lv % 26 + xv + rv % 12);
				dst[j3] = 8'(int'(dst[j3]) + xv + sv % 15);
				dst[j6] = 8'(int'(dst[j6]) + xv % 7 + sv % 13);
			end
		end
		return dst;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
		fails++;
	endtask

	// predict one accepted word
	task automatic predict(input logic [1:0] act, input logic [7:0] b, input logic last,
		input logic first);
		cipher_word_t w;
		byte_arr_t src, work;
		int n, p, l;
		if (act == xcs_pkg::ACT_KEY) begin
			if (key_count < xcs_pkg::MAX_KEY_BYTES) begin
				key_bytes[key_count] = b;
				key_count++;
			end else
				key_spill = 1'b1;
			if (!last)
				return;
			n = key_count;
			w.rbyte = 8'd0;
			if (key_spill) begin
				w.st = xcs_pkg::ST_KEY_LONG;
				have_key = 1'b0;
			end else if (n < xcs_pkg::MIN_KEY_BYTES) begin
				w.st = xcs_pkg::ST_KEY_SHORT;
				have_key = 1'b0;
			end else begin
				src = '{default: 8'd0};
				for (int i = 0; i < n; i++)
					src[i] = key_bytes[i];
				work = schedule_pass(src, n);
				for (int i = 0; i < xcs_pkg::SALT_LEN; i++)
					work[2 * n + i] = SALT[i];
				stream_tab = schedule_pass(work, 2 * n + xcs_pkg::SALT_LEN);
				tab_len = 4 * n + 2 * xcs_pkg::SALT_LEN;
				have_key = 1'b1;
				tab_pos = 0;
				chain = 8'd0;
				w.st = xcs_pkg::ST_KEY_READY;
				keys_made++;
			end
			key_count = 0;
			key_spill = 1'b0;
			expected_words.push_back(w);
			return;
		end
		if (act == xcs_pkg::ACT_NONE)
			return;
		if (!have_key) begin
			w.rbyte = 8'd0;
			w.st = xcs_pkg::ST_NO_KEY;
			expected_words.push_back(w);
			return;
		end
		if (first) begin
			tab_pos = 0;
			chain = 8'd0;
		end
		l = tab_len;
		p = tab_pos % l;
		w.rbyte = b ^ stream_tab[p] ^ stream_tab[(p + l - 2) % l]
			^ stream_tab[(p + 3) % l] ^ chain;
		w.st = xcs_pkg::ST_DATA;
		chain = (act == xcs_pkg::ACT_ENC) ? w.rbyte : b;
		tab_pos = (p + 1) % l;
		expected_words.push_back(w);
	endtask

	// sample both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		cipher_word_t w;
		if (!arst_n) begin
			expected_words.delete();
			key_count = 0;
			key_spill = 1'b0;
			tab_len = 0;
			have_key = 1'b0;
			tab_pos = 0;
			chain = 8'd0;
			fails = 0;
			pending = 0;
			words_out = 0;
			keys_made = 0;
		end else begin
			if (out_valid && out_ready) begin
				words_out++;
				if (expected_words.size() == 0) begin
					report("unexpected word, result_byte", result_byte, 0);
				end else begin
					w = expected_words.pop_front();
					if (status !== w.st)
						report("status", status, w.st);
					if (result_byte !== w.rbyte)
						report("result_byte", result_byte, w.rbyte);
				end
			end
			if (in_valid && in_ready)
				predict(action, data_byte, key_last, msg_start);
			pending = expected_words.size();
		end
	end

endmodule

>>> test/tb_xor_chained_stream_cipher_top.sv
// stimulus and verdict for the chained stream cipher
// depends on xcs_pkg, xor_chained_stream_cipher_top and xcs_checker
`timescale 1ns / 100ps
module tb_xor_chained_stream_cipher_top;

	localparam int WORD_GOAL = 1550;
	localparam int STALL_LIMIT = 60000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] action;
	logic [7:0] data_byte;
	logic       key_last;
	logic       msg_start;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] result_byte;
	logic [2:0] status;

	int fails, pending, words_out, keys_made;
	int words_sent;
	int send_idle_pct, recv_stall_pct;
	int hold_cycles;
	int quiet_cycles;

	xor_chained_stream_cipher_top dut (.*);

	xcs_checker chk (.*);

	// clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver: long hold-off when asked, else random stalls per phase
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// offer one word and hold it until taken, then maybe idle
	task automatic send(input logic [1:0] a, input logic [7:0] b, input logic last,
		input logic first);
		@(negedge clk);
		in_valid = 1'b1;
		action = a;
		data_byte = b;
		key_last = last;
		msg_start = first;
		do
			@(posedge clk);
		while (!in_ready);
		if (a != xcs_pkg::ACT_NONE)
			words_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(4)) @(negedge clk);
		end
	endtask

	task automatic load_key(input int n);
		for (int i = 0; i < n; i++)
			send(xcs_pkg::ACT_KEY, 8'($urandom), i == n - 1, 1'($urandom_range(1)));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// random traffic: mostly well-formed key then messages, some noise
	task automatic random_phase(input int goal);
		int len;
		logic [1:0] a;
		while (words_sent < goal) begin
			case ($urandom_range(19))
				0: load_key($urandom_range(2, 1));
				1: load_key($urandom_range(xcs_pkg::MAX_KEY_BYTES + 4,
					xcs_pkg::MAX_KEY_BYTES + 1));
				2: load_key(($urandom_range(3) == 0) ? xcs_pkg::MAX_KEY_BYTES
					: $urandom_range(xcs_pkg::MAX_KEY_BYTES - 1, 7));
				3, 4: load_key($urandom_range(6, xcs_pkg::MIN_KEY_BYTES));
				5: send(xcs_pkg::ACT_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
				default: begin
					a = $urandom_range(1) ? xcs_pkg::ACT_ENC : xcs_pkg::ACT_DEC;
					len = $urandom_range(30, 1);
					for (int i = 0; i < len; i++)
						send(a, 8'($urandom), 1'($urandom),
							i == 0 || $urandom_range(19) == 0);
				end
			endcase
		end
	endtask

	initial begin
		in_valid = 1'b0;
		action = xcs_pkg::ACT_KEY;
		data_byte = 8'd0;
		key_last = 1'b0;
		msg_start = 1'b0;
		out_ready = 1'b0;
		hold_cycles = 0;
		quiet_cycles = 0;
		words_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: no key, ignored action, short, single, overlong and minimal keys
		send(xcs_pkg::ACT_ENC, 8'h00, 1'b0, 1'b1);
		send(xcs_pkg::ACT_DEC, 8'hFF, 1'b1, 1'b0);
		send(xcs_pkg::ACT_NONE, 8'hFF, 1'b1, 1'b1);
		send(xcs_pkg::ACT_KEY, 8'h80, 1'b0, 1'b1);
		send(xcs_pkg::ACT_KEY, 8'h7F, 1'b1, 1'b0);
		send(xcs_pkg::ACT_KEY, 8'hFF, 1'b1, 1'b0);
		for (int i = 0; i <= xcs_pkg::MAX_KEY_BYTES; i++)
			send(xcs_pkg::ACT_KEY, 8'(i * 37), i == xcs_pkg::MAX_KEY_BYTES, 1'b0);
		send(xcs_pkg::ACT_KEY, 8'h00, 1'b0, 1'b0);
		send(xcs_pkg::ACT_KEY, 8'hFF, 1'b0, 1'b1);
		send(xcs_pkg::ACT_KEY, 8'h80, 1'b1, 1'b0);
		send(xcs_pkg::ACT_ENC, 8'hFF, 1'b0, 1'b1);
		send(xcs_pkg::ACT_ENC, 8'h00, 1'b0, 1'b0);
		send(xcs_pkg::ACT_DEC, 8'h5A, 1'b0, 1'b1);
		send(xcs_pkg::ACT_DEC, 8'hA5, 1'b0, 1'b0);
		drain();

		// back-pressure: receiver holds off while the sender keeps offering
		load_key(5);
		drain();
		hold_cycles = 300;
		for (int i = 0; i < 12; i++)
			send(xcs_pkg::ACT_ENC, 8'($urandom), 1'b0, i == 0);
		drain();

		// random phases with different idle mixes
		random_phase(WORD_GOAL / 4);
		send_idle_pct = 75;
		random_phase(WORD_GOAL / 2);
		send_idle_pct = 0;
		recv_stall_pct = 75;
		random_phase(3 * WORD_GOAL / 4);
		send_idle_pct = 36;
		recv_stall_pct = 36;
		random_phase(WORD_GOAL);
		drain();
		repeat (50) @(posedge clk);

		$display("sent %0d words, checked %0d results, %0d keys expanded", words_sent,
			words_out, keys_made);
		$display("covered no-key, short, overlong and good keys, both directions, all stall mixes");
		if (fails == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> filelist.f
design/xcs_pkg.sv
design/xcs_front.sv
design/xcs_back.sv
design/xor_chained_stream_cipher_top.sv
test/xcs_checker.sv
test/tb_xor_chained_stream_cipher_top.sv
